FILE: sv/swle_pkg.sv
// ----------------------------------------------------------------------------
// Soft wrap line editor package
// Shared types, constants and helper functions for the line editor.
// ----------------------------------------------------------------------------
package swle_pkg;

    // Buffer and view geometry.
    localparam int BUF_CHARS = 256;
    localparam int ROWS_MAX  = 8;
    localparam int MIN_WRAP  = 8;

    // Special byte values.
    localparam logic [7:0] NEWLINE_BYTE    = 8'h0A;
    localparam logic [7:0] DEL_BYTE        = 8'h7F;
    localparam logic [7:0] FIRST_PRINTABLE = 8'd32;
    localparam logic [7:0] MAX_LENGTH      = 8'd255;
    localparam logic [7:0] WRAP_RESET      = 8'd40;

    // Row or index marker that never matches a real row or index.
    localparam logic [8:0] NO_MATCH = 9'h1FF;

    // Editing actions carried in the input beat.
    typedef enum logic [2:0] {
        ACT_INSERT = 3'd0,
        ACT_BACKSP = 3'd1,
        ACT_DELETE = 3'd2,
        ACT_MOVE   = 3'd3,
        ACT_ROW    = 3'd4,
        ACT_SCROLL = 3'd5,
        ACT_CLEAR  = 3'd6,
        ACT_TAKE   = 3'd7
    } action_t;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_PRE_INIT,
        S_PRE_WALK,
        S_DECIDE,
        S_INS_INIT,
        S_INS_STEP,
        S_DEL_INIT,
        S_DEL_STEP,
        S_ROW_INIT,
        S_ROW_WALK,
        S_POST_INIT,
        S_POST_WALK,
        S_FINISH
    } state_t;

    // Purpose of a layout walk.
    typedef enum logic [1:0] {
        WM_CARET,
        WM_ROW
    } walk_mode_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       accept;
        logic       walk_init;
        logic       walk_step;
        walk_mode_t walk_mode;
        logic       decide;
        logic       ins_init;
        logic       ins_step;
        logic       del_init;
        logic       del_step;
        logic       finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic walk_done;
        logic go_ins;
        logic go_del;
        logic go_row;
        logic shift_done;
        logic out_free;
    } stat_t;

    // Visible rows for a total visual row count.
    function automatic logic [3:0] vis_of(input logic [8:0] total);
        logic [3:0] res;
        if (total == 9'd0) begin
            res = 4'd1;
        end else if (total > 9'(ROWS_MAX)) begin
            res = 4'(ROWS_MAX);
        end else begin
            res = total[3:0];
        end
        return res;
    endfunction

endpackage

FILE: sv/swle_ctrl.sv
// ----------------------------------------------------------------------------
// Soft wrap line editor controller
// Sequences the layout walks, byte shifts and result hand-off for one item.
// ----------------------------------------------------------------------------
module swle_ctrl import swle_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_tvalid,
    output logic   s_tready,
    input  stat_t  stat,
    output cmd_t   cmd
);

    state_t state_reg, state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:      if (s_tvalid) state_next = S_PRE_INIT;
            S_PRE_INIT:  state_next = S_PRE_WALK;
            S_PRE_WALK:  if (stat.walk_done) state_next = S_DECIDE;
            S_DECIDE: begin
                priority if (stat.go_ins) state_next = S_INS_INIT;
                else if (stat.go_del)     state_next = S_DEL_INIT;
                else if (stat.go_row)     state_next = S_ROW_INIT;
                else                      state_next = S_POST_INIT;
            end
            S_INS_INIT:  state_next = S_INS_STEP;
            S_INS_STEP:  if (stat.shift_done) state_next = S_POST_INIT;
            S_DEL_INIT:  state_next = S_DEL_STEP;
            S_DEL_STEP:  if (stat.shift_done) state_next = S_POST_INIT;
            S_ROW_INIT:  state_next = S_ROW_WALK;
            S_ROW_WALK:  if (stat.walk_done) state_next = S_POST_INIT;
            S_POST_INIT: state_next = S_POST_WALK;
            S_POST_WALK: if (stat.walk_done) state_next = S_FINISH;
            S_FINISH:    if (stat.out_free) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // Commands.
    always_comb begin
        cmd = '0;
        cmd.walk_mode = WM_CARET;
        s_tready = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:      cmd.accept = s_tvalid;
            S_PRE_INIT:  cmd.walk_init = 1'b1;
            S_PRE_WALK:  cmd.walk_step = 1'b1;
            S_DECIDE:    cmd.decide = 1'b1;
            S_INS_INIT:  cmd.ins_init = 1'b1;
            S_INS_STEP:  cmd.ins_step = 1'b1;
            S_DEL_INIT:  cmd.del_init = 1'b1;
            S_DEL_STEP:  cmd.del_step = 1'b1;
            S_ROW_INIT: begin
                cmd.walk_init = 1'b1;
                cmd.walk_mode = WM_ROW;
            end
            S_ROW_WALK: begin
                cmd.walk_step = 1'b1;
                cmd.walk_mode = WM_ROW;
            end
            S_POST_INIT: cmd.walk_init = 1'b1;
            S_POST_WALK: cmd.walk_step = 1'b1;
            S_FINISH:    cmd.finish = stat.out_free;
            default:     cmd = '0;
        endcase
    end

endmodule

FILE: sv/swle_datapath.sv
// ----------------------------------------------------------------------------
// Soft wrap line editor datapath
// Line buffer memory, editor registers, layout walker and result register.
// ----------------------------------------------------------------------------
module swle_datapath import swle_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [7:0]   cfg_wdata,
    input  logic [2:0]   in_action,
    input  logic [7:0]   in_char,
    input  logic [10:0]  in_delta,
    input  cmd_t         cmd,
    output stat_t        stat,
    input  logic         m_tready,
    output logic         m_tvalid,
    output logic [47:0]  m_tdata
);

    // Item and editor state.
    action_t            act_reg;
    logic [7:0]         ch_reg;
    logic signed [10:0] delta_reg;
    logic [7:0]         len_reg, caret_reg, scroll_reg, wrap_reg;
    logic               pend_reg, seen_reg, stat_reg, kcv_reg, nh_reg;
    logic [3:0]         pre_vis_reg;
    logic [7:0]         tgt_reg;

    // Line buffer.
    logic [7:0] mem [BUF_CHARS];
    logic [7:0] rdata_reg;
    logic [7:0] raddr, waddr, wdata;
    logic       we;

    // Walker.
    logic [7:0] idx_reg, row_reg, col_reg, wcol_reg, hit_reg;
    logic [8:0] want_reg, target_reg;
    logic       found_reg;
    logic [7:0] w_row_reg, w_col_reg;
    logic [8:0] w_total_reg;

    logic       m_valid_reg;
    logic [47:0] m_data_reg;

    logic [7:0] wrap_eff;
    assign wrap_eff = (wrap_reg < 8'(MIN_WRAP)) ? 8'(MIN_WRAP) : wrap_reg;

    // Walker step decode.
    logic       at_end, row_is_tgt, hit_now, step_found;
    logic [7:0] step_hit;
    assign at_end     = (idx_reg == len_reg);
    assign row_is_tgt = ({1'b0, row_reg} == target_reg);
    assign hit_now    = !found_reg && row_is_tgt && (col_reg == wcol_reg);

    always_comb begin
        step_found = found_reg;
        step_hit   = hit_reg;
        if (!found_reg) begin
            priority if (hit_now) begin
                step_found = 1'b1;
                step_hit   = idx_reg;
            end else if (at_end) begin
                step_found = 1'b1;
                step_hit   = len_reg;
            end else if (row_is_tgt &&
                         ((rdata_reg == NEWLINE_BYTE) || (col_reg >= wrap_eff))) begin
                step_found = 1'b1;
                step_hit   = idx_reg;
            end else begin
                step_found = 1'b0;
            end
        end
    end

    // Decision arithmetic from the layout before the edit.
    logic signed [11:0] dlt12, t_move, t_row, t_sc, imax12;
    logic [3:0]         vis_pre, vis_post;
    logic [8:0]         imax;
    logic               ins_bad, go_ins, go_del, go_row, row_bad;

    assign dlt12   = 12'(delta_reg);
    assign t_move  = $signed({4'b0000, caret_reg}) + dlt12;
    assign t_row   = $signed({4'b0000, w_row_reg}) + dlt12;
    assign t_sc    = $signed({4'b0000, scroll_reg}) + dlt12;
    assign vis_pre = vis_of(w_total_reg);
    assign vis_post = vis_pre;
    assign imax    = (w_total_reg > {5'd0, vis_pre}) ? (w_total_reg - {5'd0, vis_pre}) : 9'd0;
    assign imax12  = $signed({3'b000, imax});
    assign ins_bad = ((ch_reg != NEWLINE_BYTE) &&
                      ((ch_reg < FIRST_PRINTABLE) || (ch_reg == DEL_BYTE))) ||
                     (({1'b0, len_reg} + 9'd1) >= 9'(BUF_CHARS)) ||
                     (len_reg >= MAX_LENGTH);
    assign row_bad = (delta_reg == 11'sd0) || (t_row < 12'sd0) ||
                     (t_row >= $signed({3'b000, w_total_reg}));
    assign go_ins  = (act_reg == ACT_INSERT) && !ins_bad;
    assign go_del  = ((act_reg == ACT_BACKSP) && (caret_reg != 8'd0)) ||
                     ((act_reg == ACT_DELETE) && (caret_reg < len_reg));
    assign go_row  = (act_reg == ACT_ROW) && !row_bad;

    // Caret-visible scroll from the layout after the edit.
    logic [8:0] max_off, first, last_lo;
    logic [9:0] first_end;
    logic [7:0] scroll_fin;
    assign max_off   = w_total_reg - {5'd0, vis_post};
    assign first     = max_off - {1'b0, scroll_reg};
    assign first_end = {1'b0, first} + {6'd0, vis_post};
    assign last_lo   = {1'b0, w_row_reg} - {5'd0, vis_post} + 9'd1;

    always_comb begin
        scroll_fin = scroll_reg;
        if (kcv_reg) begin
            priority if (w_total_reg <= {5'd0, vis_post}) begin
                scroll_fin = 8'd0;
            end else if ({1'b0, scroll_reg} > max_off) begin
                scroll_fin = ({1'b0, w_row_reg} <= max_off) ?
                             8'(max_off - {1'b0, w_row_reg}) : max_off[7:0];
            end else if ({1'b0, w_row_reg} < first) begin
                scroll_fin = 8'(max_off - {1'b0, w_row_reg});
            end else if ({2'b00, w_row_reg} >= first_end) begin
                scroll_fin = 8'(max_off - last_lo);
            end else begin
                scroll_fin = scroll_reg;
            end
        end
    end

    // Memory address and write selection.
    always_comb begin
        we    = 1'b0;
        waddr = idx_reg;
        wdata = rdata_reg;
        raddr = idx_reg + 8'd1;
        priority if (cmd.walk_init) begin
            raddr = 8'd0;
        end else if (cmd.ins_init) begin
            raddr = len_reg - 8'd1;
        end else if (cmd.ins_step) begin
            raddr = idx_reg - 8'd2;
            we    = 1'b1;
            if (idx_reg == caret_reg) begin
                waddr = caret_reg;
                wdata = ch_reg;
            end
        end else if (cmd.del_init) begin
            raddr = caret_reg + 8'd1;
        end else if (cmd.del_step) begin
            raddr = idx_reg + 8'd2;
            we    = stat.shift_done ? 1'b0 : 1'b1;
        end else begin
            raddr = idx_reg + 8'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    // Status to the controller.
    always_comb begin
        stat.walk_done  = cmd.walk_step && at_end;
        stat.go_ins     = go_ins;
        stat.go_del     = go_del;
        stat.go_row     = go_row;
        stat.shift_done = cmd.ins_step ? (idx_reg == caret_reg) :
                          (({1'b0, idx_reg} + 9'd1) >= {1'b0, len_reg});
        stat.out_free   = !m_valid_reg || m_tready;
    end

    // Item capture, walker and shift counters (payload, no reset).
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            act_reg   <= action_t'(in_action);
            ch_reg    <= in_char;
            delta_reg <= in_delta;
        end
        if (cmd.walk_init) begin
            idx_reg   <= 8'd0;
            row_reg   <= 8'd0;
            col_reg   <= 8'd0;
            found_reg <= 1'b0;
            w_row_reg <= 8'd0;
            w_col_reg <= 8'd0;
            wcol_reg  <= w_col_reg;
            if (cmd.walk_mode == WM_ROW) begin
                want_reg   <= NO_MATCH;
                target_reg <= {1'b0, tgt_reg};
            end else begin
                want_reg   <= {1'b0, caret_reg};
                target_reg <= NO_MATCH;
            end
        end else if (cmd.walk_step) begin
            found_reg <= step_found;
            hit_reg   <= step_hit;
            if ({1'b0, idx_reg} == want_reg) begin
                w_row_reg <= row_reg;
                w_col_reg <= col_reg;
            end
            if (at_end) begin
                w_total_reg <= {1'b0, row_reg} + 9'd1;
            end else begin
                idx_reg <= idx_reg + 8'd1;
                if (rdata_reg == NEWLINE_BYTE) begin
                    row_reg <= row_reg + 8'd1;
                    col_reg <= 8'd0;
                end else if (col_reg >= wrap_eff) begin
                    row_reg <= row_reg + 8'd1;
                    col_reg <= 8'd1;
                end else begin
                    col_reg <= col_reg + 8'd1;
                end
            end
        end else if (cmd.ins_init) begin
            idx_reg <= len_reg;
        end else if (cmd.ins_step) begin
            idx_reg <= idx_reg - 8'd1;
        end else if (cmd.del_init) begin
            idx_reg <= caret_reg;
        end else if (cmd.del_step) begin
            idx_reg <= idx_reg + 8'd1;
        end
        if (cmd.decide) begin
            pre_vis_reg <= vis_pre;
            tgt_reg     <= t_row[7:0];
        end
        if (cmd.finish) begin
            m_data_reg <= {2'b00, seen_reg, vis_post, scroll_fin, w_col_reg, w_row_reg,
                           caret_reg, len_reg, stat_reg};
        end
    end

    // Editor control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= 8'd0;
            caret_reg   <= 8'd0;
            scroll_reg  <= 8'd0;
            pend_reg    <= 1'b0;
            seen_reg    <= 1'b0;
            stat_reg    <= 1'b0;
            kcv_reg     <= 1'b0;
            nh_reg      <= 1'b0;
            wrap_reg    <= WRAP_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                wrap_reg <= cfg_wdata;
            end
            if (cmd.decide) begin
                seen_reg <= 1'b0;
                stat_reg <= 1'b0;
                kcv_reg  <= 1'b0;
                nh_reg   <= 1'b0;
                unique case (act_reg)
                    ACT_INSERT: begin
                        stat_reg <= ins_bad;
                        kcv_reg  <= !ins_bad;
                        nh_reg   <= !ins_bad;
                    end
                    ACT_BACKSP, ACT_DELETE: begin
                        stat_reg <= !go_del;
                        kcv_reg  <= go_del;
                        nh_reg   <= go_del;
                        if (go_del && (act_reg == ACT_BACKSP)) begin
                            caret_reg <= caret_reg - 8'd1;
                        end
                    end
                    ACT_MOVE: begin
                        kcv_reg <= 1'b1;
                        priority if (t_move < 12'sd0) begin
                            caret_reg <= 8'd0;
                            stat_reg  <= (caret_reg == 8'd0);
                        end else if (t_move > $signed({4'b0000, len_reg})) begin
                            caret_reg <= len_reg;
                            stat_reg  <= (caret_reg == len_reg);
                        end else begin
                            caret_reg <= t_move[7:0];
                            stat_reg  <= (t_move[7:0] == caret_reg);
                        end
                    end
                    ACT_ROW: begin
                        stat_reg <= row_bad;
                        kcv_reg  <= !row_bad;
                    end
                    ACT_SCROLL: begin
                        if (delta_reg == 11'sd0) begin
                            stat_reg <= 1'b1;
                        end else if (t_sc < 12'sd0) begin
                            scroll_reg <= 8'd0;
                            stat_reg   <= (scroll_reg == 8'd0);
                        end else if (t_sc > imax12) begin
                            scroll_reg <= imax[7:0];
                            stat_reg   <= (scroll_reg == imax[7:0]);
                        end else begin
                            scroll_reg <= t_sc[7:0];
                            stat_reg   <= (t_sc[7:0] == scroll_reg);
                        end
                    end
                    ACT_CLEAR: begin
                        len_reg    <= 8'd0;
                        caret_reg  <= 8'd0;
                        scroll_reg <= 8'd0;
                    end
                    ACT_TAKE: begin
                        seen_reg <= pend_reg;
                        pend_reg <= 1'b0;
                    end
                    default: stat_reg <= 1'b0;
                endcase
            end
            // Insert finishes by placing the byte and advancing the caret.
            if (cmd.ins_step && stat.shift_done) begin
                len_reg   <= len_reg + 8'd1;
                caret_reg <= caret_reg + 8'd1;
            end
            if (cmd.del_step && stat.shift_done) begin
                len_reg <= len_reg - 8'd1;
            end
            // A row walk lands the caret on the target cell.
            if (cmd.walk_step && at_end && (cmd.walk_mode == WM_ROW)) begin
                caret_reg <= step_hit;
            end
            if (cmd.finish) begin
                scroll_reg <= scroll_fin;
                if (nh_reg && (vis_post != pre_vis_reg)) begin
                    pend_reg <= 1'b1;
                end
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

FILE: sv/soft_wrap_line_editor.sv
// Items are handled one at a time; s_tready rises together with m_tvalid, so the
// next item is accepted only once the previous result beat is presented, and a
// result stall also holds back the next item.
// Reset: synchronous active-low aresetn clears the line, caret, view offset and
// relayout flag and sets the wrap width to 40; buffer contents are not cleared.
// ----------------------------------------------------------------------------
// Soft wrap line editor
// Edits a byte line under a caret and tracks its soft-wrapped layout.
// ----------------------------------------------------------------------------
module soft_wrap_line_editor import swle_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [7:0]   cfg_wdata,      // wrap_columns
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,        // char_code[7:0], delta[18:8], zero fill
    input  logic [2:0]   s_tuser,        // action[2:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata         // status, text_length, caret_index,
                                         // caret_row, caret_column, view_offset,
                                         // shown_rows[44:41], relayout_seen[45]
);

    cmd_t  cmd;
    stat_t stat;

    swle_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    swle_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_action (s_tuser),
        .in_char   (s_tdata[7:0]),
        .in_delta  (s_tdata[18:8]),
        .cmd       (cmd),
        .stat      (stat),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule

FILE: sv/swle_checker.sv
// ----------------------------------------------------------------------------
// Soft wrap line editor checker
// Port-level properties of the line editor, bound to the top level.
// ----------------------------------------------------------------------------
module swle_checker import swle_pkg::*; (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [47:0]  m_tdata
);

    // A stalled result beat holds its data.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // The caret never sits past the end of the line.
    a_caret: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[16:9] <= m_tdata[8:1])
        else $error("caret beyond text length");

    // Visible rows stay within one and the row limit.
    a_rows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[44:41] != 4'd0 && m_tdata[44:41] <= 4'(ROWS_MAX))
        else $error("visible row count out of range");

    // No input beat is taken in the cycle right after one was taken.
    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second beat accepted while busy");

endmodule

bind soft_wrap_line_editor swle_checker u_swle_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Soft wrap line editor testbench
// Drives editing beats with random idling on both sides, predicts every
// result beat from a behavioral model of the editor and compares field by field.
// ----------------------------------------------------------------------------
module tb import swle_pkg::*; ();

    typedef struct packed {
        action_t     act;
        logic [7:0]  ch;
        logic [10:0] delta;
    } edit_t;

    typedef struct packed {
        logic        status;
        logic [7:0]  length;
        logic [7:0]  caret;
        logic [7:0]  row;
        logic [7:0]  col;
        logic [7:0]  offset;
        logic [3:0]  shown;
        logic        seen;
    } view_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        in_taken;

    // Model state of the editor.
    logic [7:0] text_mem [BUF_CHARS];
    int         text_len;
    int         caret_pos;
    int         scroll_pos;
    logic       relayout_flag;
    int         wrap_width;

    edit_t pending_edits[$];
    view_t expected_views[$];
    int    send_idle_pct;
    int    recv_idle_pct;
    int    error_count;
    int    sent_count;

    soft_wrap_line_editor u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // Walk the line: total rows, plus row and column of index want.
    function automatic int walk_rows(input int want, output int wrow, output int wcol);
        int wrap;
        int row;
        int col;
        wrap = (wrap_width < MIN_WRAP) ? MIN_WRAP : wrap_width;
        row = 0;
        col = 0;
        wrow = 0;
        wcol = 0;
        for (int i = 0; i <= text_len; i++) begin
            if (i == want) begin
                wrow = row;
                wcol = col;
            end
            if (i == text_len) break;
            if (text_mem[i] == NEWLINE_BYTE) begin
                row++;
                col = 0;
            end else begin
                if (col >= wrap) begin
                    row++;
                    col = 0;
                end
                col++;
            end
        end
        return row + 1;
    endfunction

    function automatic int rows_shown(input int total);
        if (total < 1) return 1;
        return (total > ROWS_MAX) ? ROWS_MAX : total;
    endfunction

    function automatic int shown_now();
        int r;
        int c;
        return rows_shown(walk_rows(-1, r, c));
    endfunction

    // Byte index at a visual row and column, or the end of that row.
    function automatic int index_of_cell(input int target, input int keep_col);
        int wrap;
        int row;
        int col;
        wrap = (wrap_width < MIN_WRAP) ? MIN_WRAP : wrap_width;
        row = 0;
        col = 0;
        for (int i = 0; i <= text_len; i++) begin
            if (row == target && col == keep_col) return i;
            if (i == text_len) break;
            if (text_mem[i] == NEWLINE_BYTE) begin
                if (row == target) return i;
                row++;
                col = 0;
            end else begin
                if (col >= wrap) begin
                    if (row == target) return i;
                    row++;
                    col = 0;
                end
                col++;
            end
        end
        return text_len;
    endfunction

    // Scroll so that the caret row lies inside the visible window.
    function automatic void follow_caret();
        int row;
        int col;
        int total;
        int vis;
        int max_off;
        int first;
        total = walk_rows(caret_pos, row, col);
        vis = rows_shown(total);
        if (total <= vis) begin
            scroll_pos = 0;
            return;
        end
        max_off = total - vis;
        if (scroll_pos > max_off) begin
            scroll_pos = (row <= max_off) ? (max_off - row) : max_off;
            return;
        end
        first = max_off - scroll_pos;
        if (row < first) scroll_pos = max_off - row;
        else if (row >= first + vis) scroll_pos = max_off - (row - vis + 1);
    endfunction

    // Apply one edit to the model and return the result beat it causes.
    function automatic view_t apply_edit(input edit_t e);
        view_t v;
        int    d;
        int    t;
        int    vis_before;
        int    row;
        int    col;
        int    total;
        int    lim;
        logic  rejected;
        logic  seen;
        d = $signed(e.delta);
        rejected = 1'b0;
        seen = 1'b0;
        case (e.act)
            ACT_INSERT: begin
                if ((e.ch != NEWLINE_BYTE && (e.ch < FIRST_PRINTABLE || e.ch == DEL_BYTE))
                        || text_len + 1 >= BUF_CHARS || text_len >= MAX_LENGTH) begin
                    rejected = 1'b1;
                end else begin
                    vis_before = shown_now();
                    for (int i = text_len; i > caret_pos; i--) text_mem[i] = text_mem[i-1];
                    text_mem[caret_pos] = e.ch;
                    text_len++;
                    caret_pos++;
                    follow_caret();
                    if (shown_now() != vis_before) relayout_flag = 1'b1;
                end
            end
            ACT_BACKSP, ACT_DELETE: begin
                if ((e.act == ACT_BACKSP && caret_pos == 0) ||
                        (e.act == ACT_DELETE && caret_pos >= text_len)) begin
                    rejected = 1'b1;
                end else begin
                    vis_before = shown_now();
                    if (e.act == ACT_BACKSP) caret_pos--;
                    for (int i = caret_pos; i + 1 < text_len; i++) text_mem[i] = text_mem[i+1];
                    text_len--;
                    follow_caret();
                    if (shown_now() != vis_before) relayout_flag = 1'b1;
                end
            end
            ACT_MOVE: begin
                t = caret_pos + d;
                if (t < 0) t = 0;
                if (t > text_len) t = text_len;
                rejected = (t == caret_pos);
                caret_pos = t;
                follow_caret();
            end
            ACT_ROW: begin
                if (d == 0) begin
                    rejected = 1'b1;
                end else begin
                    total = walk_rows(caret_pos, row, col);
                    t = row + d;
                    if (t < 0 || t >= total) begin
                        rejected = 1'b1;
                    end else begin
                        caret_pos = index_of_cell(t, col);
                        follow_caret();
                    end
                end
            end
            ACT_SCROLL: begin
                if (d == 0) begin
                    rejected = 1'b1;
                end else begin
                    vis_before = scroll_pos;
                    t = scroll_pos + d;
                    if (t < 0) t = 0;
                    total = walk_rows(-1, row, col);
                    lim = (total > rows_shown(total)) ? total - rows_shown(total) : 0;
                    scroll_pos = (t > lim) ? lim : t;
                    rejected = (scroll_pos == vis_before);
                end
            end
            ACT_CLEAR: begin
                text_len = 0;
                caret_pos = 0;
                scroll_pos = 0;
            end
            default: begin
                seen = relayout_flag;
                relayout_flag = 1'b0;
            end
        endcase
        total = walk_rows(caret_pos, row, col);
        v.status = rejected;
        v.length = 8'(text_len);
        v.caret  = 8'(caret_pos);
        v.row    = 8'(row);
        v.col    = 8'(col);
        v.offset = 8'(scroll_pos);
        v.shown  = 4'(rows_shown(total));
        v.seen   = seen;
        return v;
    endfunction

    // Driver: present queued beats at the falling edge.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (pending_edits.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tuser  <= pending_edits[0].act;
                s_tdata  <= {5'd0, pending_edits[0].delta, pending_edits[0].ch};
                void'(pending_edits.pop_front());
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: predict on accepted inputs, check accepted results.
    always @(posedge aclk) begin
        view_t got;
        view_t exp;
        edit_t e;
        in_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            e.act   = action_t'(s_tuser);
            e.ch    = s_tdata[7:0];
            e.delta = s_tdata[18:8];
            expected_views.push_back(apply_edit(e));
            sent_count++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tdata[0];
            got.length = m_tdata[8:1];
            got.caret  = m_tdata[16:9];
            got.row    = m_tdata[24:17];
            got.col    = m_tdata[32:25];
            got.offset = m_tdata[40:33];
            got.shown  = m_tdata[44:41];
            got.seen   = m_tdata[45];
            if (expected_views.size() == 0) begin
                $error("result beat with no expected result");
                error_count++;
            end else begin
                exp = expected_views.pop_front();
                if (got.status != exp.status) begin
                    $error("status: expected %0d, actual %0d", exp.status, got.status);
                    error_count++;
                end
                if (got.length != exp.length) begin
                    $error("text_length: expected %0d, actual %0d", exp.length, got.length);
                    error_count++;
                end
                if (got.caret != exp.caret) begin
                    $error("caret_index: expected %0d, actual %0d", exp.caret, got.caret);
                    error_count++;
                end
                if (got.row != exp.row) begin
                    $error("caret_row: expected %0d, actual %0d", exp.row, got.row);
                    error_count++;
                end
                if (got.col != exp.col) begin
                    $error("caret_column: expected %0d, actual %0d", exp.col, got.col);
                    error_count++;
                end
                if (got.offset != exp.offset) begin
                    $error("view_offset: expected %0d, actual %0d", exp.offset, got.offset);
                    error_count++;
                end
                if (got.shown != exp.shown) begin
                    $error("shown_rows: expected %0d, actual %0d", exp.shown, got.shown);
                    error_count++;
                end
                if (got.seen != exp.seen) begin
                    $error("relayout_seen: expected %0d, actual %0d", exp.seen, got.seen);
                    error_count++;
                end
            end
        end
    end

    function automatic edit_t make_edit(input action_t a, input int c, input int d);
        edit_t e;
        e.act = a;
        e.ch = 8'(c);
        e.delta = 11'(d);
        return e;
    endfunction

    // Random edit, weighted toward printable inserts so lines grow long.
    function automatic edit_t random_edit();
        int pick;
        int c;
        int d;
        pick = $urandom_range(99);
        c = $urandom_range(255);
        if ($urandom_range(3) != 0) c = $urandom_range(32, 126);
        if ($urandom_range(9) == 0) c = NEWLINE_BYTE;
        case ($urandom_range(3))
            0: d = $urandom_range(2047) - 1024;
            default: d = $urandom_range(16) - 8;
        endcase
        if (pick < 45) return make_edit(ACT_INSERT, c, d);
        if (pick < 53) return make_edit(ACT_BACKSP, c, d);
        if (pick < 60) return make_edit(ACT_DELETE, c, d);
        if (pick < 72) return make_edit(ACT_MOVE, c, d);
        if (pick < 84) return make_edit(ACT_ROW, c, d);
        if (pick < 93) return make_edit(ACT_SCROLL, c, d);
        if (pick < 95) return make_edit(ACT_CLEAR, c, d);
        return make_edit(ACT_TAKE, c, d);
    endfunction

    task automatic drain();
        while (pending_edits.size() > 0 || expected_views.size() > 0 || s_tvalid)
            @(posedge aclk);
        repeat (600) @(posedge aclk);
    endtask

    task automatic set_wrap(input int w);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= 8'(w);
        wrap_width = w;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int wraps[6];
        wraps = '{40, 8, 255, 13, 8, 100};
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        error_count = 0;
        sent_count = 0;
        text_len = 0;
        caret_pos = 0;
        scroll_pos = 0;
        relayout_flag = 1'b0;
        wrap_width = WRAP_RESET;
        send_idle_pct = 25;
        recv_idle_pct = 50;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: rejects on empty line, extremes, every action.
        pending_edits.push_back(make_edit(ACT_BACKSP, 0, 0));
        pending_edits.push_back(make_edit(ACT_DELETE, 0, 0));
        pending_edits.push_back(make_edit(ACT_INSERT, 8'h00, 0));
        pending_edits.push_back(make_edit(ACT_INSERT, DEL_BYTE, 0));
        pending_edits.push_back(make_edit(ACT_INSERT, 31, 0));
        pending_edits.push_back(make_edit(ACT_INSERT, 32, 0));
        pending_edits.push_back(make_edit(ACT_INSERT, 8'hFF, 0));
        pending_edits.push_back(make_edit(ACT_INSERT, NEWLINE_BYTE, 0));
        pending_edits.push_back(make_edit(ACT_INSERT, 126, 0));
        pending_edits.push_back(make_edit(ACT_INSERT, 128, 0));
        pending_edits.push_back(make_edit(ACT_MOVE, 0, -1024));
        pending_edits.push_back(make_edit(ACT_MOVE, 0, 0));
        pending_edits.push_back(make_edit(ACT_MOVE, 0, 1023));
        pending_edits.push_back(make_edit(ACT_ROW, 0, 0));
        pending_edits.push_back(make_edit(ACT_ROW, 0, -1));
        pending_edits.push_back(make_edit(ACT_ROW, 0, 1023));
        pending_edits.push_back(make_edit(ACT_SCROLL, 0, 0));
        pending_edits.push_back(make_edit(ACT_SCROLL, 0, -1024));
        pending_edits.push_back(make_edit(ACT_TAKE, 0, 0));
        pending_edits.push_back(make_edit(ACT_MOVE, 0, -2));
        pending_edits.push_back(make_edit(ACT_DELETE, 0, 0));
        pending_edits.push_back(make_edit(ACT_BACKSP, 0, 0));
        pending_edits.push_back(make_edit(ACT_CLEAR, 0, 0));
        pending_edits.push_back(make_edit(ACT_TAKE, 0, 0));
        drain();

        // Random phases under several wrap widths; fill to the buffer limit.
        for (int p = 0; p < 6; p++) begin
            set_wrap(wraps[p]);
            if (p == 2) begin
                send_idle_pct = 50;
                recv_idle_pct = 25;
            end else if (p == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (p == 1) begin
                for (int i = 0; i < 260; i++)
                    pending_edits.push_back(make_edit(ACT_INSERT,
                        ($urandom_range(7) == 0) ? NEWLINE_BYTE : $urandom_range(32, 126), 0));
                for (int i = 0; i < 30; i++) pending_edits.push_back(random_edit());
            end else begin
                for (int i = 0; i < 320; i++) pending_edits.push_back(random_edit());
            end
            drain();
        end

        if (error_count == 0) begin
            $display("[soft_wrap_line_editor] OK");
        end else begin
            $display("[soft_wrap_line_editor] ERROR");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #100ms;
        $display("[soft_wrap_line_editor] ERROR");
        $finish;
    end

endmodule
